@@ sv/gcca_pkg.sv @@
// ----------------------------------------------------------------------------
// gcca_pkg
// shared types, constants and helper functions for the grid cell averager
// ----------------------------------------------------------------------------
package gcca_pkg;

    localparam int CELL_COUNT  = 9;
    localparam int CELL_IDX_W  = 4;
    localparam int COORD_W     = 11;
    localparam int CENTER_W    = 10;
    localparam int COLOR_W     = 8;
    localparam int SUM_W       = 22;

    // band edges relative to the grid center
    localparam int OUTER_EDGE  = 148;
    localparam int GAP_EDGE    = 52;
    localparam int INNER_EDGE  = 48;

    // divide by 96*96 = 9 * 1024: drop ten bits, then scale by 7282/65536
    localparam int AVG_SHIFT     = 10;
    localparam int AVG_TRUNC_W   = SUM_W - AVG_SHIFT;
    localparam int AVG_RECIP     = 7282;
    localparam int AVG_RECIP_SH  = 16;
    localparam int AVG_PROD_W    = 25;
    localparam int AVG_SAT_LIMIT = 255 * 9;

    localparam logic [SUM_W-1:0]      SUM_MAX       = '1;
    localparam logic [CENTER_W-1:0]   CENTER_X_INIT = CENTER_W'(320);
    localparam logic [CENTER_W-1:0]   CENTER_Y_INIT = CENTER_W'(240);
    localparam logic [CELL_IDX_W-1:0] LAST_CELL_IDX = CELL_IDX_W'(CELL_COUNT - 1);

    // register byte addresses, decoded on address bit 2
    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    typedef enum logic [1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2,
        BAND_NONE = 2'd3
    } band_t;

    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } sum_triple_t;

    typedef struct packed {
        logic                  pending;
        logic                  last;
        logic [CELL_IDX_W-1:0] index;
    } emit_status_t;

    function automatic band_t band_of(input logic [COORD_W-1:0] pos,
                                      input logic [CENTER_W-1:0] centre);
        logic signed [COORD_W:0] d;
        band_t                   b;
        d = signed'({1'b0, pos}) - signed'({2'b00, centre});
        if (d > -OUTER_EDGE && d < -GAP_EDGE)
        begin
            b = BAND_LOW;
        end
        else if (d > -INNER_EDGE && d < INNER_EDGE)
        begin
            b = BAND_MID;
        end
        else if (d > GAP_EDGE && d < OUTER_EDGE)
        begin
            b = BAND_HIGH;
        end
        else
        begin
            b = BAND_NONE;
        end
        return b;
    endfunction

    function automatic logic [CELL_IDX_W-1:0] cell_of(input band_t row, input band_t col);
        logic [CELL_IDX_W-1:0] r;
        logic [CELL_IDX_W-1:0] c;
        r = {2'b00, row};
        c = {2'b00, col};
        return (r << 1) + r + c;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                 input logic [COLOR_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + (SUM_W+1)'(v);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] avg_of(input logic [SUM_W-1:0] sum);
        logic [AVG_TRUNC_W-1:0] t;
        logic [AVG_PROD_W-1:0]  p;
        t = sum[SUM_W-1:AVG_SHIFT];
        p = AVG_PROD_W'(t) * AVG_PROD_W'(AVG_RECIP);
        return (int'(t) >= AVG_SAT_LIMIT) ? '1 : p[AVG_RECIP_SH +: COLOR_W];
    endfunction

endpackage

@@ sv/gcca_accum.sv @@
// ----------------------------------------------------------------------------
// gcca_accum
// pixel input register, cell classification, per-cell sums and result bank
// ----------------------------------------------------------------------------
module gcca_accum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [gcca_pkg::CENTER_W-1:0]        center_x,
    input  logic [gcca_pkg::CENTER_W-1:0]        center_y,
    input  logic                                 pixel_valid,
    output logic                                 pixel_stall,
    input  logic [gcca_pkg::COORD_W-1:0]         pixel_x,
    input  logic [gcca_pkg::COORD_W-1:0]         pixel_y,
    input  logic [gcca_pkg::COLOR_W-1:0]         blue,
    input  logic [gcca_pkg::COLOR_W-1:0]         green,
    input  logic [gcca_pkg::COLOR_W-1:0]         red,
    input  logic                                 frame_end,
    input  logic                                 pop,
    output gcca_pkg::sum_triple_t                head,
    output gcca_pkg::emit_status_t               status
);

    logic                          s1_valid_reg;
    logic [gcca_pkg::COORD_W-1:0]  s1_x_reg;
    logic [gcca_pkg::COORD_W-1:0]  s1_y_reg;
    logic [gcca_pkg::COLOR_W-1:0]  s1_blue_reg;
    logic [gcca_pkg::COLOR_W-1:0]  s1_green_reg;
    logic [gcca_pkg::COLOR_W-1:0]  s1_red_reg;
    logic                          s1_fe_reg;

    gcca_pkg::sum_triple_t         sums_reg [gcca_pkg::CELL_COUNT];
    gcca_pkg::sum_triple_t         bank_reg [gcca_pkg::CELL_COUNT];
    logic [gcca_pkg::CELL_IDX_W-1:0] count_reg;
    logic [gcca_pkg::CELL_IDX_W-1:0] count_next;

    logic                          s1_blocked;
    logic                          s1_fire;
    gcca_pkg::band_t               col_band;
    gcca_pkg::band_t               row_band;
    logic                          hit;
    logic [gcca_pkg::CELL_IDX_W-1:0] cell_sel;
    gcca_pkg::sum_triple_t         cur;
    gcca_pkg::sum_triple_t         upd;

    // a frame end waits while the previous frame's results are still queued
    assign s1_blocked  = s1_valid_reg && s1_fe_reg && (count_reg != '0);
    assign s1_fire     = s1_valid_reg && !s1_blocked;
    assign pixel_stall = s1_blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_blocked)
        begin
            s1_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid && !s1_blocked)
        begin
            s1_x_reg     <= pixel_x;
            s1_y_reg     <= pixel_y;
            s1_blue_reg  <= blue;
            s1_green_reg <= green;
            s1_red_reg   <= red;
            s1_fe_reg    <= frame_end;
        end
    end

    always_comb
    begin
        col_band  = gcca_pkg::band_of(s1_x_reg, center_x);
        row_band  = gcca_pkg::band_of(s1_y_reg, center_y);
        hit       = (col_band != gcca_pkg::BAND_NONE) && (row_band != gcca_pkg::BAND_NONE);
        cell_sel  = hit ? gcca_pkg::cell_of(row_band, col_band) : '0;
        cur       = sums_reg[cell_sel];
        upd.blue  = gcca_pkg::sat_add(cur.blue,  s1_blue_reg);
        upd.green = gcca_pkg::sat_add(cur.green, s1_green_reg);
        upd.red   = gcca_pkg::sat_add(cur.red,   s1_red_reg);
    end

    // sums: accumulate, cleared once the frame has been copied to the bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gcca_pkg::CELL_COUNT; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            if (s1_fe_reg)
            begin
                for (int i = 0; i < gcca_pkg::CELL_COUNT; i++)
                begin
                    sums_reg[i] <= '0;
                end
            end
            else if (hit)
            begin
                sums_reg[cell_sel] <= upd;
            end
        end
    end

    // result bank: loaded at frame end, shifts toward entry 0 on each pop
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_fe_reg)
        begin
            for (int i = 0; i < gcca_pkg::CELL_COUNT; i++)
            begin
                bank_reg[i] <= (hit && cell_sel == gcca_pkg::CELL_IDX_W'(i)) ? upd : sums_reg[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < gcca_pkg::CELL_COUNT - 1; i++)
            begin
                bank_reg[i] <= bank_reg[i+1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (s1_fire && s1_fe_reg)
        begin
            count_next = gcca_pkg::CELL_IDX_W'(gcca_pkg::CELL_COUNT);
        end
        else if (pop && count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head           = bank_reg[0];
    assign status.pending = (count_reg != '0);
    assign status.last    = (count_reg == gcca_pkg::CELL_IDX_W'(1));
    assign status.index   = gcca_pkg::CELL_IDX_W'(gcca_pkg::CELL_COUNT) - count_reg;

endmodule

@@ sv/grid_cell_color_averager.sv @@
// ----------------------------------------------------------------------------
// grid_cell_color_averager
// Takes one BGR pixel per clock with its column and row and sorts it into one
// of nine cells of a 3x3 grid centred on (center_x, center_y); each axis has
// the open bands (c-148,c-52), (c-48,c+48), (c+52,c+148), and pixels outside
// every cell are dropped. Blue, green and red are summed per cell in 22-bit
// saturating sums. The pixel flagged frame_end is added, then the nine sums
// are copied to a result bank and cleared, and the bank drains one word per
// cycle unless result_stall holds it, cells 0 to 8, each the sum divided by
// 9216 (saturated at 255), with last_cell on cell 8. Rate: one pixel per cycle
// unless pixel_stall is high; results pass from the input register via the
// bank to the output. The single nine-entry result bank sets the limit:
// a frame_end pixel that arrives while the previous frame's nine words are
// still draining waits (pixel_stall high) until the last of them has left the
// bank, so frame ends must be at least ten cycles apart to run unstalled.
// Registers: center_x at byte 0, center_y at byte 4, 10 bits each.
// ----------------------------------------------------------------------------
module grid_cell_color_averager (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // pixel channel
    input  logic                                 pixel_valid,
    output logic                                 pixel_stall,
    input  logic [gcca_pkg::COORD_W-1:0]         pixel_x,
    input  logic [gcca_pkg::COORD_W-1:0]         pixel_y,
    input  logic [gcca_pkg::COLOR_W-1:0]         blue,
    input  logic [gcca_pkg::COLOR_W-1:0]         green,
    input  logic [gcca_pkg::COLOR_W-1:0]         red,
    input  logic                                 frame_end,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [gcca_pkg::CELL_IDX_W-1:0]      cell_index,
    output logic [gcca_pkg::COLOR_W-1:0]         avg_blue,
    output logic [gcca_pkg::COLOR_W-1:0]         avg_green,
    output logic [gcca_pkg::COLOR_W-1:0]         avg_red,
    output logic                                 last_cell
);

    logic [gcca_pkg::CENTER_W-1:0]   center_x_reg;
    logic [gcca_pkg::CENTER_W-1:0]   center_y_reg;
    logic                            cfg_write;

    gcca_pkg::sum_triple_t           head;
    gcca_pkg::emit_status_t          status;
    logic                            out_free;
    logic                            pop;

    logic                            result_valid_reg;
    logic [gcca_pkg::CELL_IDX_W-1:0] cell_index_reg;
    logic [gcca_pkg::COLOR_W-1:0]    avg_blue_reg;
    logic [gcca_pkg::COLOR_W-1:0]    avg_green_reg;
    logic [gcca_pkg::COLOR_W-1:0]    avg_red_reg;
    logic                            last_cell_reg;

    // register file: address bit 2 picks the register, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= gcca_pkg::CENTER_X_INIT;
            center_y_reg <= gcca_pkg::CENTER_Y_INIT;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                gcca_pkg::REG_CENTER_X: center_x_reg <= pwdata[gcca_pkg::CENTER_W-1:0];
                gcca_pkg::REG_CENTER_Y: center_y_reg <= pwdata[gcca_pkg::CENTER_W-1:0];
                default:                center_x_reg <= center_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            gcca_pkg::REG_CENTER_X: prdata = 32'(center_x_reg);
            gcca_pkg::REG_CENTER_Y: prdata = 32'(center_y_reg);
            default:                prdata = '0;
        endcase
    end

    // classification, sums and the nine-entry result bank
    gcca_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .frame_end   (frame_end),
        .pop         (pop),
        .head        (head),
        .status      (status)
    );

    // output register: takes the bank head whenever it is empty or draining
    assign out_free = !result_valid_reg || !result_stall;
    assign pop      = status.pending && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= status.pending;
        end
    end

    // divide by 9216 on the way out of the bank
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cell_index_reg <= status.index;
            avg_blue_reg   <= gcca_pkg::avg_of(head.blue);
            avg_green_reg  <= gcca_pkg::avg_of(head.green);
            avg_red_reg    <= gcca_pkg::avg_of(head.red);
            last_cell_reg  <= status.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign cell_index   = cell_index_reg;
    assign avg_blue     = avg_blue_reg;
    assign avg_green    = avg_green_reg;
    assign avg_red      = avg_red_reg;
    assign last_cell    = last_cell_reg;

`ifndef SYNTH
    // the flagged word is always cell 8
    a_last_is_cell8: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_cell |-> cell_index == gcca_pkg::LAST_CELL_IDX)
        else $error("last_cell raised on a cell other than 8");

    // pixels stall only behind a frame still draining from the bank
    a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> status.pending)
        else $error("pixel input stalled with an empty result bank");

    // the bank empties only by handing out its last word
    a_bank_drains_fully: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(status.pending) |-> $past(status.last) && $past(pop))
        else $error("result bank emptied before cell 8 was sent");

    // a popped last word shows up flagged in the output register
    a_last_pop_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        pop && status.last |=> result_valid && last_cell)
        else $error("last bank word not flagged at the output");
`endif

endmodule
